/* rtl/core/gwtl_pkg.sv */
`timescale 1ns / 1ps

package gwtl_pkg;

   localparam int CHAR_W     = 8;
   localparam int LEN_W      = 13;
   localparam int DIM_W      = 9;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CHAR_W-1:0] CHAR_ENDPOINT   = 8'd68;  // 'D'
   localparam logic [CHAR_W-1:0] CHAR_CHECKPOINT = 8'd49;  // '1'
   localparam logic [LEN_W-1:0]  LEN_MAX         = 13'd8191;
   localparam logic [DIM_W-1:0]  DIM_RESET       = 9'd8;

   // register select, taken from paddr bit 2
   localparam logic REG_GRID_ROWS = 1'b0;
   localparam logic REG_GRID_COLS = 1'b1;

   typedef logic [1:0] dist_sel_type;
   localparam dist_sel_type DSEL_START_END = 2'd0;
   localparam dist_sel_type DSEL_START_WP  = 2'd1;
   localparam dist_sel_type DSEL_WP_WP     = 2'd2;
   localparam dist_sel_type DSEL_WP_END    = 2'd3;

   typedef logic [2:0] best_op_type;
   localparam best_op_type BEST_HOLD = 3'd0;
   localparam best_op_type BEST_LOAD = 3'd1;
   localparam best_op_type BEST_MIN  = 3'd2;
   localparam best_op_type BEST_INF  = 3'd3;
   localparam best_op_type BEST_ZERO = 3'd4;

   typedef struct packed {
      logic         scan_en;
      logic         mask_init;
      logic         mask_inc;
      logic         i_clear;
      logic         i_inc;
      logic         j_clear;
      logic         j_inc;
      dist_sel_type dsel;
      best_op_type  best_op;
      logic         cost_we;
      logic         fin_phase;
      logic         push;
   } cmd_type;

   typedef struct packed {
      logic grid_done;
      logic ovf;
      logic cnt_zero;
      logic i_in_mask;
      logic prev_zero;
      logic j_in_prev;
      logic j_last;
      logic i_last;
      logic mask_full;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/gwtl_req_if.sv */
`timescale 1ns / 1ps

interface gwtl_req_if;
   logic                        valid;
   logic                        ready;
   logic [gwtl_pkg::CHAR_W-1:0] cell_char;

   modport source (output valid, output cell_char, input ready);
   modport sink (input valid, input cell_char, output ready);
endinterface

/* rtl/core/gwtl_rsp_if.sv */
`timescale 1ns / 1ps

interface gwtl_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [gwtl_pkg::LEN_W-1:0] path_length;
   logic                       too_many_checkpoints;

   modport source (output valid, output path_length, output too_many_checkpoints,
                   input ready);
   modport sink (input valid, input path_length, input too_many_checkpoints,
                 output ready);
endinterface

/* rtl/core/gwtl_ram.sv */
`timescale 1ns / 1ps

module gwtl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/core/gwtl_ctrl.sv */
`timescale 1ns / 1ps

module gwtl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  gwtl_pkg::status_type st,
   output gwtl_pkg::cmd_type    cmd
);
   localparam logic [3:0] S_SCAN  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_ISEL  = 4'd2;
   localparam logic [3:0] S_IWAIT = 4'd3;
   localparam logic [3:0] S_JSEL  = 4'd4;
   localparam logic [3:0] S_JACC  = 4'd5;
   localparam logic [3:0] S_WRITE = 4'd6;
   localparam logic [3:0] S_INEXT = 4'd7;
   localparam logic [3:0] S_FSEL  = 4'd8;
   localparam logic [3:0] S_FACC  = 4'd9;
   localparam logic [3:0] S_PUSH  = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SCAN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      cmd.dsel = gwtl_pkg::DSEL_START_END;
      cmd.best_op = gwtl_pkg::BEST_HOLD;
      state_in = state_ff;
      case (state_ff)
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (st.grid_done) begin
               state_in = S_START;
            end
         end
         S_START: begin
            if (st.ovf) begin
               cmd.best_op = gwtl_pkg::BEST_ZERO;
               state_in    = S_PUSH;
            end else if (st.cnt_zero) begin
               cmd.dsel    = gwtl_pkg::DSEL_START_END;
               cmd.best_op = gwtl_pkg::BEST_LOAD;
               state_in    = S_PUSH;
            end else begin
               cmd.mask_init = 1'b1;
               state_in      = S_ISEL;
            end
         end
         S_ISEL: begin
            state_in = st.i_in_mask ? S_IWAIT : S_INEXT;
         end
         S_IWAIT: begin
            if (st.prev_zero) begin
               cmd.dsel    = gwtl_pkg::DSEL_START_WP;
               cmd.best_op = gwtl_pkg::BEST_LOAD;
               state_in    = S_WRITE;
            end else begin
               cmd.best_op = gwtl_pkg::BEST_INF;
               cmd.j_clear = 1'b1;
               state_in    = S_JSEL;
            end
         end
         S_JSEL: begin
            if (st.j_in_prev) begin
               state_in = S_JACC;
            end else if (st.j_last) begin
               state_in = S_WRITE;
            end else begin
               cmd.j_inc = 1'b1;
            end
         end
         S_JACC: begin
            cmd.dsel    = gwtl_pkg::DSEL_WP_WP;
            cmd.best_op = gwtl_pkg::BEST_MIN;
            if (st.j_last) begin
               state_in = S_WRITE;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = S_JSEL;
            end
         end
         S_WRITE: begin
            cmd.cost_we = 1'b1;
            state_in    = S_INEXT;
         end
         S_INEXT: begin
            if (st.i_last) begin
               cmd.i_clear = 1'b1;
               if (st.mask_full) begin
                  cmd.best_op = gwtl_pkg::BEST_INF;
                  state_in    = S_FSEL;
               end else begin
                  cmd.mask_inc = 1'b1;
                  state_in     = S_ISEL;
               end
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_ISEL;
            end
         end
         S_FSEL: begin
            cmd.fin_phase = 1'b1;
            state_in      = S_FACC;
         end
         S_FACC: begin
            cmd.fin_phase = 1'b1;
            cmd.dsel      = gwtl_pkg::DSEL_WP_END;
            cmd.best_op   = gwtl_pkg::BEST_MIN;
            if (st.i_last) begin
               state_in = S_PUSH;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_FSEL;
            end
         end
         S_PUSH: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               state_in = S_SCAN;
            end
         end
         default: begin
            state_in = S_SCAN;
         end
      endcase
   end
endmodule

/* rtl/core/gwtl_dpath.sv */
`timescale 1ns / 1ps

module gwtl_dpath #(
   parameter int MAX_CHECKPOINTS = 8,
   parameter int MAX_DIM         = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gwtl_pkg::cmd_type                    cmd,
   output gwtl_pkg::status_type                 st,
   input  logic [gwtl_pkg::DIM_W-1:0]           grid_rows,
   input  logic [gwtl_pkg::DIM_W-1:0]           grid_cols,
   input  logic                                 req_valid,
   input  logic [gwtl_pkg::CHAR_W-1:0]          req_cell_char,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [gwtl_pkg::LEN_W-1:0]           rsp_path_length,
   output logic                                 rsp_too_many_checkpoints
);
   localparam int K      = MAX_CHECKPOINTS;
   localparam int DIMCAP = (MAX_DIM > 8) ? MAX_DIM : 8;
   localparam int PW     = $clog2(DIMCAP);
   localparam int DW     = PW + 1;
   localparam int CMPW   = (PW + 1 > gwtl_pkg::DIM_W) ? PW + 1 : gwtl_pkg::DIM_W;
   localparam int IW     = (K > 1) ? $clog2(K) : 1;
   localparam int CW     = $clog2(K + 1);
   localparam int AW     = K + IW;
   localparam int SUMW   = ((DW > gwtl_pkg::LEN_W) ? DW : gwtl_pkg::LEN_W) + 1;
   localparam int BW     = gwtl_pkg::LEN_W + 1;

   localparam logic [BW-1:0] BEST_INF_VAL = {BW{1'b1}};

   function automatic logic [DW-1:0] leg_dist(input logic [2*PW-1:0] a,
                                              input logic [2*PW-1:0] b);
      logic [PW-1:0] dr;
      logic [PW-1:0] dc;
      dr = (a[2*PW-1:PW] > b[2*PW-1:PW]) ? a[2*PW-1:PW] - b[2*PW-1:PW]
                                         : b[2*PW-1:PW] - a[2*PW-1:PW];
      dc = (a[PW-1:0] > b[PW-1:0]) ? a[PW-1:0] - b[PW-1:0] : b[PW-1:0] - a[PW-1:0];
      return DW'(dr) + DW'(dc);
   endfunction

   // scan state
   logic [PW-1:0]   row_ff, col_ff;
   logic            seen_ff, ovf_ff;
   logic [2*PW-1:0] start_ff, end_ff;
   logic [CW-1:0]   count_ff;

   // DP state
   logic [K-1:0]    mask_ff;
   logic [IW-1:0]   i_ff, j_ff;
   logic [BW-1:0]   best_ff;

   // result register
   logic                       rsp_valid_ff;
   logic [gwtl_pkg::LEN_W-1:0] rsp_len_ff;
   logic                       rsp_ovf_ff;

   logic            accept;
   logic            col_last, row_last;
   logic [2*PW-1:0] here;
   logic            is_end, is_cp, wp_we;
   logic [K-1:0]    prev, full;
   logic [2*PW-1:0] wpa, wpb, pa, pb;
   logic [gwtl_pkg::LEN_W-1:0] cost_rd, base, cand;
   logic [DW-1:0]   d;
   logic [SUMW-1:0] sum;
   logic [AW-1:0]   cost_raddr;

   assign accept   = req_valid & cmd.scan_en;
   assign here     = {row_ff, col_ff};
   assign is_end   = (req_cell_char == gwtl_pkg::CHAR_ENDPOINT);
   assign is_cp    = (req_cell_char == gwtl_pkg::CHAR_CHECKPOINT);
   assign wp_we    = accept & is_cp & (count_ff != CW'(K));
   assign col_last = (CMPW'(col_ff) + CMPW'(1)) >= CMPW'(grid_cols);
   assign row_last = (CMPW'(row_ff) + CMPW'(1)) >= CMPW'(grid_rows);

   assign prev = mask_ff & ~(K'(1) << i_ff);
   assign full = K'((((K + 1)'(1)) << count_ff) - (K + 1)'(1));

   assign cost_raddr = cmd.fin_phase ? {mask_ff, i_ff} : {prev, j_ff};

   gwtl_ram #(.WIDTH(2 * PW), .DEPTH(K)) u_wp_a (
      .clock (clock),
      .we    (wp_we),
      .waddr (count_ff[IW-1:0]),
      .wdata (here),
      .raddr (i_ff),
      .rdata (wpa)
   );

   gwtl_ram #(.WIDTH(2 * PW), .DEPTH(K)) u_wp_b (
      .clock (clock),
      .we    (wp_we),
      .waddr (count_ff[IW-1:0]),
      .wdata (here),
      .raddr (j_ff),
      .rdata (wpb)
   );

   gwtl_ram #(.WIDTH(gwtl_pkg::LEN_W), .DEPTH(1 << AW)) u_cost (
      .clock (clock),
      .we    (cmd.cost_we),
      .waddr ({mask_ff, i_ff}),
      .wdata (best_ff[gwtl_pkg::LEN_W-1:0]),
      .raddr (cost_raddr),
      .rdata (cost_rd)
   );

   // shared leg unit: saturating base plus Manhattan distance
   always_comb begin
      case (cmd.dsel)
         gwtl_pkg::DSEL_START_END: begin pa = start_ff; pb = end_ff; end
         gwtl_pkg::DSEL_START_WP:  begin pa = start_ff; pb = wpa;    end
         gwtl_pkg::DSEL_WP_WP:     begin pa = wpb;      pb = wpa;    end
         gwtl_pkg::DSEL_WP_END:    begin pa = wpa;      pb = end_ff; end
         default:                  begin pa = start_ff; pb = end_ff; end
      endcase
      base = (cmd.dsel == gwtl_pkg::DSEL_START_END || cmd.dsel == gwtl_pkg::DSEL_START_WP)
             ? '0 : cost_rd;
      d    = leg_dist(pa, pb);
      sum  = SUMW'(base) + SUMW'(d);
      cand = (sum > SUMW'(gwtl_pkg::LEN_MAX)) ? gwtl_pkg::LEN_MAX
                                              : sum[gwtl_pkg::LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.push) begin
         row_ff   <= '0;
         col_ff   <= '0;
         seen_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
         start_ff <= '0;
         end_ff   <= '0;
         count_ff <= '0;
      end else if (accept) begin
         if (is_end) begin
            if (!seen_ff) begin
               start_ff <= here;
               seen_ff  <= 1'b1;
            end else begin
               end_ff <= here;
            end
         end else if (is_cp) begin
            if (count_ff != CW'(K)) begin
               count_ff <= count_ff + CW'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (col_last) begin
            col_ff <= '0;
            if (!row_last) begin
               row_ff <= row_ff + PW'(1);
            end
         end else begin
            col_ff <= col_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         i_ff    <= '0;
         j_ff    <= '0;
      end else begin
         if (cmd.mask_init) begin
            mask_ff <= K'(1);
         end else if (cmd.mask_inc) begin
            mask_ff <= mask_ff + K'(1);
         end
         if (cmd.mask_init || cmd.i_clear) begin
            i_ff <= '0;
         end else if (cmd.i_inc) begin
            i_ff <= i_ff + IW'(1);
         end
         if (cmd.j_clear) begin
            j_ff <= '0;
         end else if (cmd.j_inc) begin
            j_ff <= j_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.best_op)
         gwtl_pkg::BEST_LOAD: best_ff <= {1'b0, cand};
         gwtl_pkg::BEST_MIN: begin
            if ({1'b0, cand} < best_ff) begin
               best_ff <= {1'b0, cand};
            end
         end
         gwtl_pkg::BEST_INF:  best_ff <= BEST_INF_VAL;
         gwtl_pkg::BEST_ZERO: best_ff <= '0;
         default:             best_ff <= best_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_len_ff <= best_ff[gwtl_pkg::LEN_W-1:0];
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_path_length          = rsp_len_ff;
   assign rsp_too_many_checkpoints = rsp_ovf_ff;

   assign st.grid_done = accept & col_last & row_last;
   assign st.ovf       = ovf_ff;
   assign st.cnt_zero  = (count_ff == '0);
   assign st.i_in_mask = mask_ff[i_ff];
   assign st.prev_zero = (prev == '0);
   assign st.j_in_prev = prev[j_ff];
   assign st.j_last    = (CW'(j_ff) + CW'(1)) == count_ff;
   assign st.i_last    = (CW'(i_ff) + CW'(1)) == count_ff;
   assign st.mask_full = (mask_ff == full);
   assign st.out_free  = ~rsp_valid_ff | rsp_ready;
endmodule

/* rtl/core/grid_waypoint_tour_length_unit.sv */
`timescale 1ns / 1ps

// Grid waypoint tour length unit.
// req_ch carries one grid character per transaction, row by row, left to
// right, over grid_rows x grid_cols cells set through the APB-style port
// (register 0 at 0x0 is the row count, register 1 at 0x4 the column count).
// 'D' marks the start on its first occurrence and the end after that; '1'
// marks a checkpoint. After the last cell one transaction on rsp_ch gives
// the shortest start -> all checkpoints -> end length, or a zero length
// with too_many_checkpoints set when the grid held too many checkpoints.
// Cells are taken one per cycle while the sequencer scans. After the last cell
// the input is held off while a Held-Karp pass runs on one shared leg unit
// and one cost memory over the 2^k - 1 masks: for each checkpoint in a mask
// it stores the shortest path from the start through the rest of the mask
// to that checkpoint; then the legs to the end are taken. With no
// checkpoints, or too many, the pass is skipped.
// The result waits in an output register; a stalled receiver holds it and
// the next grid is taken meanwhile, only its result waits for the slot.
// Reset restores 8 x 8 and empties the scan and result; no memory clearing
// pass is needed.
module grid_waypoint_tour_length_unit #(
   parameter int MAX_CHECKPOINTS = 8,
   parameter int MAX_DIM         = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   gwtl_req_if.sink                           req_ch,
   gwtl_rsp_if.source                         rsp_ch,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [gwtl_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [gwtl_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [gwtl_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   logic [gwtl_pkg::DIM_W-1:0] rows_ff, cols_ff;
   logic [gwtl_pkg::DIM_W-1:0] wr_val;
   logic                       csr_we;
   gwtl_pkg::cmd_type          cmd;
   gwtl_pkg::status_type       st;

   // Clamp a written dimension into 1..MAX_DIM
   always_comb begin
      wr_val = pwdata[gwtl_pkg::DIM_W-1:0];
      if (wr_val == '0) begin
         wr_val = gwtl_pkg::DIM_W'(1);
      end else if (int'(wr_val) > MAX_DIM) begin
         wr_val = gwtl_pkg::DIM_W'(MAX_DIM);
      end
   end

   assign csr_we = psel & penable & pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= gwtl_pkg::DIM_RESET;
         cols_ff <= gwtl_pkg::DIM_RESET;
      end else if (csr_we) begin
         if (paddr[2] == gwtl_pkg::REG_GRID_COLS) begin
            cols_ff <= wr_val;
         end else begin
            rows_ff <= wr_val;
         end
      end
   end

   assign prdata = (paddr[2] == gwtl_pkg::REG_GRID_ROWS)
                   ? gwtl_pkg::CSR_DATA_W'(rows_ff) : gwtl_pkg::CSR_DATA_W'(cols_ff);

   // Take cells only while the sequencer is scanning
   assign req_ch.ready = cmd.scan_en;

   gwtl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   gwtl_dpath #(
      .MAX_CHECKPOINTS (MAX_CHECKPOINTS),
      .MAX_DIM         (MAX_DIM)
   ) u_dpath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .st                       (st),
      .grid_rows                (rows_ff),
      .grid_cols                (cols_ff),
      .req_valid                (req_ch.valid),
      .req_cell_char            (req_ch.cell_char),
      .rsp_ready                (rsp_ch.ready),
      .rsp_valid                (rsp_ch.valid),
      .rsp_path_length          (rsp_ch.path_length),
      .rsp_too_many_checkpoints (rsp_ch.too_many_checkpoints)
   );
endmodule
